@@ hdl/ppcf_pkg.sv @@
// Shared types and constants for the polygon point cull filter.
package ppcf_pkg;

    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 5;
    localparam int BITS_W  = 32;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int MIN_VERTICES     = 3;

    localparam logic [CNT_W-1:0] VERTEX_COUNT_RESET = CNT_W'(MIN_VERTICES);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    localparam logic STATUS_KEPT       = 1'b0;
    localparam logic STATUS_NOT_LOADED = 1'b1;

    // One word travelling down the row of edge cells.
    typedef struct packed {
        logic                      vld;
        logic                      cmd;
        logic [IDX_W-1:0]          idx;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [BITS_W-1:0]         z;
        logic [BITS_W-1:0]         inten;
        logic                      loaded;
        logic                      parity;
        logic                      onb;
    } item_t;

endpackage

@@ hdl/polygon_point_cull_filter.sv @@
// Top level of the polygon point cull filter: entry logic, row of edge cells and output register.
//
// The filter takes one word per cycle on the s_ side and runs it down a row of
// MAX_VERTICES edge cells, three register stages per cell (differences, the two
// cross products, then the subtract and the even-odd and boundary update); a
// word passes every cell's three registers and then the output register before
// its result, if it has one, appears on m_.
// Sustained throughput is one word per cycle; when the output
// register holds a result that is not taken, the whole row stalls and s_tready
// falls. A vertex write (tuser = 0) travels the row too and updates each cell's
// copy of the vertex as it passes, so points keep strict order with table
// writes. A point gives a result only when it lies strictly outside the polygon
// (status 0, fields unchanged) or when some slot in use has never been written
// (status 1, all fields zero). vertex_count is written through the cfg_ port,
// which the user must do only while the filter is idle; the block does not
// enforce it. Values below three act as three and values above MAX_VERTICES act as MAX_VERTICES.
module polygon_point_cull_filter #(
    parameter int MAX_VERTICES = ppcf_pkg::MAX_VERTICES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // s_tdata, lowest bit up: vertex_index[3:0], x_pos[27:4], y_pos[51:28],
    // z_bits[83:52], intensity_bits[115:84], zero pad[119:116]
    input  logic [119:0]                s_tdata,
    // s_tuser: cmd (0 = vertex write, 1 = point)
    input  logic                        s_tuser,
    // Result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // m_tdata, lowest bit up: out_x[23:0], out_y[47:24], out_z_bits[79:48],
    // out_intensity_bits[111:80]
    output logic [111:0]                m_tdata,
    // m_tuser: status (0 = point kept, 1 = polygon not loaded)
    output logic                        m_tuser,
    // Configuration: vertex_count
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ppcf_pkg::CNT_W-1:0]  cfg_data
);

    localparam int CNT_W = ppcf_pkg::CNT_W;

    logic [CNT_W-1:0]        vertex_count_reg;
    logic [CNT_W-1:0]        n_used;
    logic [MAX_VERTICES-1:0] written_mask_reg, written_mask_next;
    logic                    loaded_c;
    logic                    adv, accept;
    ppcf_pkg::item_t         entry_item;
    ppcf_pkg::item_t         chain [MAX_VERTICES+1];
    ppcf_pkg::item_t         last_item;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic                    m_tuser_reg, m_tuser_next;
    logic [111:0]            m_tdata_reg, m_tdata_next;

    // The row moves whenever the output register is free or being emptied.
    assign adv       = !m_tvalid_reg || m_tready;
    assign s_tready  = adv;
    assign accept    = s_tvalid && adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= ppcf_pkg::VERTEX_COUNT_RESET;
        end else if (cfg_valid) begin
            vertex_count_reg <= cfg_data;
        end
    end

    // Clamp the vertex count into the supported range.
    always_comb begin
        n_used = vertex_count_reg;
        if (int'(vertex_count_reg) < ppcf_pkg::MIN_VERTICES) begin
            n_used = CNT_W'(ppcf_pkg::MIN_VERTICES);
        end else if (int'(vertex_count_reg) > MAX_VERTICES) begin
            n_used = CNT_W'(MAX_VERTICES);
        end
    end

    // Written bits: set by vertex writes that fall inside the table.
    always_comb begin
        written_mask_next = written_mask_reg;
        loaded_c          = 1'b1;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            if (accept && s_tuser == ppcf_pkg::CMD_WRITE && int'(s_tdata[3:0]) == i) begin
                written_mask_next[i] = 1'b1;
            end
            if (i < int'(n_used) && !written_mask_reg[i]) begin
                loaded_c = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_mask_reg <= '0;
        end else begin
            written_mask_reg <= written_mask_next;
        end
    end

    // The loaded flag is taken at entry, so it reflects every earlier write.
    always_comb begin
        entry_item.vld    = accept;
        entry_item.cmd    = s_tuser;
        entry_item.idx    = s_tdata[3:0];
        entry_item.x      = s_tdata[27:4];
        entry_item.y      = s_tdata[51:28];
        entry_item.z      = s_tdata[83:52];
        entry_item.inten  = s_tdata[115:84];
        entry_item.loaded = loaded_c;
        entry_item.parity = 1'b0;
        entry_item.onb    = 1'b0;
    end

    assign chain[0] = entry_item;

    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
        ppcf_cell #(
            .K (k)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .n_used   (n_used),
            .in_item  (chain[k]),
            .out_item (chain[k+1])
        );
    end

    assign last_item = chain[MAX_VERTICES];

    // Decide the result of the word leaving the row.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tuser_next  = m_tuser_reg;
        m_tdata_next  = m_tdata_reg;
        if (adv) begin
            m_tvalid_next = 1'b0;
            if (last_item.vld && last_item.cmd == ppcf_pkg::CMD_POINT) begin
                if (!last_item.loaded) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = ppcf_pkg::STATUS_NOT_LOADED;
                    m_tdata_next  = '0;
                end else if (!last_item.parity && !last_item.onb) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = ppcf_pkg::STATUS_KEPT;
                    m_tdata_next  = {last_item.inten, last_item.z,
                                     last_item.y, last_item.x};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tuser_reg <= m_tuser_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ hdl/ppcf_cell.sv @@
// One edge cell: holds one polygon edge and tests each passing point against it.
module ppcf_cell #(
    parameter int K = 0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic [ppcf_pkg::CNT_W-1:0]   n_used,
    input  ppcf_pkg::item_t              in_item,
    output ppcf_pkg::item_t              out_item
);

    localparam int CW = ppcf_pkg::COORD_W;
    localparam int DW = ppcf_pkg::DIFF_W;
    localparam int PW = ppcf_pkg::PROD_W;
    localparam int XW = ppcf_pkg::CROSS_W;

    // Stored vertices: own slot, next slot and slot zero (closing edge).
    logic signed [CW-1:0] ax_reg, ay_reg, nx_x_reg, nx_y_reg, zx_reg, zy_reg;

    logic signed [CW-1:0] bx_c, by_c;
    logic                 act_c, inbox_c, cross_c, up_c, wr_c;

    // Stage 1
    ppcf_pkg::item_t      s1_item_reg;
    logic                 s1_act_reg, s1_inbox_reg, s1_cross_reg, s1_up_reg;
    logic signed [DW-1:0] dxe_reg, dye_reg, dxp_reg, dyp_reg;

    // Stage 2
    ppcf_pkg::item_t      s2_item_reg;
    logic                 s2_act_reg, s2_inbox_reg, s2_cross_reg, s2_up_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;

    // Stage 3
    logic signed [XW-1:0] cr_c;
    ppcf_pkg::item_t      out_next;
    ppcf_pkg::item_t      out_item_reg;

    assign wr_c  = adv && in_item.vld && (in_item.cmd == ppcf_pkg::CMD_WRITE);
    assign act_c = (K < int'(n_used));

    always_comb begin
        if (K + 1 == int'(n_used)) begin
            bx_c = zx_reg;
            by_c = zy_reg;
        end else begin
            bx_c = nx_x_reg;
            by_c = nx_y_reg;
        end
        inbox_c = ((in_item.x >= ax_reg && in_item.x <= bx_c) ||
                   (in_item.x >= bx_c && in_item.x <= ax_reg)) &&
                  ((in_item.y >= ay_reg && in_item.y <= by_c) ||
                   (in_item.y >= by_c && in_item.y <= ay_reg));
        cross_c = (ay_reg > in_item.y) != (by_c > in_item.y);
        up_c    = by_c > ay_reg;
    end

    // Vertex store, updated as a write word enters the cell.
    always_ff @(posedge aclk) begin
        if (wr_c) begin
            if (int'(in_item.idx) == K) begin
                ax_reg <= in_item.x;
                ay_reg <= in_item.y;
            end
            if (int'(in_item.idx) == K + 1) begin
                nx_x_reg <= in_item.x;
                nx_y_reg <= in_item.y;
            end
            if (in_item.idx == '0) begin
                zx_reg <= in_item.x;
                zy_reg <= in_item.y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_item_reg.vld <= 1'b0;
        end else if (adv) begin
            s1_item_reg  <= in_item;
            s1_act_reg   <= act_c;
            s1_inbox_reg <= inbox_c;
            s1_cross_reg <= cross_c;
            s1_up_reg    <= up_c;
            dxe_reg      <= DW'(bx_c) - DW'(ax_reg);
            dye_reg      <= DW'(by_c) - DW'(ay_reg);
            dxp_reg      <= DW'(in_item.x) - DW'(ax_reg);
            dyp_reg      <= DW'(in_item.y) - DW'(ay_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_item_reg.vld <= 1'b0;
        end else if (adv) begin
            s2_item_reg  <= s1_item_reg;
            s2_act_reg   <= s1_act_reg;
            s2_inbox_reg <= s1_inbox_reg;
            s2_cross_reg <= s1_cross_reg;
            s2_up_reg    <= s1_up_reg;
            p1_reg       <= PW'(dxe_reg * dyp_reg);
            p2_reg       <= PW'(dye_reg * dxp_reg);
        end
    end

    assign cr_c = XW'(p1_reg) - XW'(p2_reg);

    always_comb begin
        out_next = s2_item_reg;
        if (s2_act_reg && s2_item_reg.cmd == ppcf_pkg::CMD_POINT) begin
            if (cr_c == '0 && s2_inbox_reg) begin
                out_next.onb = 1'b1;
            end
            if (s2_cross_reg && (s2_up_reg ? (cr_c > 0) : (cr_c < 0))) begin
                out_next.parity = !s2_item_reg.parity;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_item_reg.vld <= 1'b0;
        end else if (adv) begin
            out_item_reg <= out_next;
        end
    end

    assign out_item = out_item_reg;

endmodule
